[design/u64alu_pkg.sv]
// ----------------------------------------------------------------------------
// u64alu_pkg: shared types of the serial unsigned ALU
// Command codes, sequencer states and the control/status bundles between the
// top level and the serial core.
// ----------------------------------------------------------------------------
`default_nettype none

package u64alu_pkg;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_MOD = 4'd4,
		CMD_POW = 4'd5,
		CMD_EQ  = 4'd6,
		CMD_LT  = 4'd7,
		CMD_LE  = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARITH,
		ST_DIV,
		ST_POW_SETUP,
		ST_POW_RUN,
		ST_FINISH
	} state_t;

	// top level to core
	typedef struct packed {
		logic start;     // input beat accepted this cycle
		logic out_free;  // output register can take a result this cycle
	} core_ctl_t;

	// core to top level
	typedef struct packed {
		logic ready;     // core idle, can start a new item
		logic done;      // result valid on the core's value output
		logic error;     // zero divisor
	} core_sts_t;

endpackage

`default_nettype wire

[design/u64alu_core.sv]
// ----------------------------------------------------------------------------
// u64alu_core: bit-serial datapath and sequencer
// Runs add/sub/compare one bit per cycle, multiply and divide one operand bit
// per cycle, and power as rounds of two serial multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module u64alu_core #(
	parameter int DATA_WIDTH = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  u64alu_pkg::core_ctl_t    ctl,
	input  u64alu_pkg::cmd_t         cmd,
	input  wire  [DATA_WIDTH-1:0]    opa,
	input  wire  [DATA_WIDTH-1:0]    opb,
	output u64alu_pkg::core_sts_t    sts,
	output logic [DATA_WIDTH-1:0]    value
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W);

	u64alu_pkg::state_t state_q, state_d;
	u64alu_pkg::cmd_t   cmd_q;

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  a_q, b_q, acc_q;
	logic [W-1:0]  x_q, y_q, z_q;
	logic [W-1:0]  sq_q, pacc_q, exp_q;
	logic          carry_q, nz_q, err_q;

	logic          last;
	logic          b_bit, sum_bit, carry_d;
	logic [W-1:0]  acc_add, z_add;
	logic [W:0]    rem_sh;
	logic [W+1:0]  rem_diff;
	logic          rem_ge;

	assign last = (cnt_q == CW'(W - 1));

	// serial add/subtract cell: subtract and compares add the inverted bit
	assign b_bit   = (cmd_q == u64alu_pkg::CMD_ADD) ? b_q[0] : ~b_q[0];
	assign sum_bit = a_q[0] ^ b_bit ^ carry_q;
	assign carry_d = (a_q[0] & b_bit) | (a_q[0] & carry_q) | (b_bit & carry_q);

	// shift-add partial products
	assign acc_add = acc_q + (b_q[0] ? a_q : '0);
	assign z_add   = z_q + (y_q[0] ? x_q : '0);

	// restoring divide step: partial remainder in x_q, dividend/quotient in a_q
	assign rem_sh   = {x_q, a_q[W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, b_q};
	assign rem_ge   = ~rem_diff[W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u64alu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		sts.ready = 1'b0;
		sts.done  = 1'b0;
		sts.error = 1'b0;
		unique case (state_q)
			u64alu_pkg::ST_IDLE: begin
				sts.ready = 1'b1;
				if (ctl.start) begin
					unique case (cmd) inside
						u64alu_pkg::CMD_ADD, u64alu_pkg::CMD_SUB, u64alu_pkg::CMD_MUL,
						u64alu_pkg::CMD_EQ, u64alu_pkg::CMD_LT, u64alu_pkg::CMD_LE: begin
							state_d = u64alu_pkg::ST_ARITH;
						end
						u64alu_pkg::CMD_DIV, u64alu_pkg::CMD_MOD: begin
							state_d = (opb == '0) ? u64alu_pkg::ST_FINISH : u64alu_pkg::ST_DIV;
						end
						u64alu_pkg::CMD_POW: begin
							state_d = u64alu_pkg::ST_POW_SETUP;
						end
						default: begin
							state_d = u64alu_pkg::ST_FINISH;
						end
					endcase
				end
			end
			u64alu_pkg::ST_ARITH, u64alu_pkg::ST_DIV: begin
				if (last) state_d = u64alu_pkg::ST_FINISH;
			end
			u64alu_pkg::ST_POW_SETUP: begin
				state_d = (exp_q == '0) ? u64alu_pkg::ST_FINISH : u64alu_pkg::ST_POW_RUN;
			end
			u64alu_pkg::ST_POW_RUN: begin
				if (last) state_d = u64alu_pkg::ST_POW_SETUP;
			end
			u64alu_pkg::ST_FINISH: begin
				sts.done  = 1'b1;
				sts.error = err_q;
				if (ctl.out_free) state_d = u64alu_pkg::ST_IDLE;
			end
			default: begin
				state_d = u64alu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			u64alu_pkg::ST_IDLE: begin
				if (ctl.start) begin
					cmd_q   <= cmd;
					a_q     <= opa;
					b_q     <= opb;
					acc_q   <= '0;
					x_q     <= '0;
					cnt_q   <= '0;
					carry_q <= (cmd != u64alu_pkg::CMD_ADD);
					nz_q    <= 1'b0;
					err_q   <= ((cmd == u64alu_pkg::CMD_DIV) || (cmd == u64alu_pkg::CMD_MOD))
					           && (opb == '0);
					sq_q    <= opa;
					pacc_q  <= W'(1);
					exp_q   <= opb;
				end
			end
			u64alu_pkg::ST_ARITH: begin
				cnt_q <= cnt_q + CW'(1);
				if (cmd_q == u64alu_pkg::CMD_MUL) begin
					acc_q <= acc_add;
					a_q   <= {a_q[W-2:0], 1'b0};
					b_q   <= {1'b0, b_q[W-1:1]};
				end else begin
					acc_q   <= {sum_bit, acc_q[W-1:1]};
					a_q     <= {1'b0, a_q[W-1:1]};
					b_q     <= {1'b0, b_q[W-1:1]};
					carry_q <= carry_d;
					nz_q    <= nz_q | sum_bit;
				end
			end
			u64alu_pkg::ST_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				x_q   <= rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
				a_q   <= {a_q[W-2:0], rem_ge};
			end
			u64alu_pkg::ST_POW_SETUP: begin
				// load both multiplies of this round: sq*sq and acc*sq
				a_q   <= sq_q;
				b_q   <= sq_q;
				acc_q <= '0;
				x_q   <= sq_q;
				y_q   <= pacc_q;
				z_q   <= '0;
				cnt_q <= '0;
			end
			u64alu_pkg::ST_POW_RUN: begin
				cnt_q <= cnt_q + CW'(1);
				acc_q <= acc_add;
				a_q   <= {a_q[W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[W-1:1]};
				z_q   <= z_add;
				x_q   <= {x_q[W-2:0], 1'b0};
				y_q   <= {1'b0, y_q[W-1:1]};
				if (last) begin
					sq_q  <= acc_add;
					exp_q <= {1'b0, exp_q[W-1:1]};
					if (exp_q[0]) pacc_q <= z_add;
				end
			end
			default: begin
			end
		endcase
	end

	// pick the result out of the working registers
	always_comb begin
		value = '0;
		if (!err_q) begin
			unique case (cmd_q) inside
				u64alu_pkg::CMD_ADD, u64alu_pkg::CMD_SUB, u64alu_pkg::CMD_MUL: value = acc_q;
				u64alu_pkg::CMD_DIV: value = a_q;
				u64alu_pkg::CMD_MOD: value = x_q;
				u64alu_pkg::CMD_POW: value = pacc_q;
				u64alu_pkg::CMD_EQ:  value = W'(!nz_q);
				u64alu_pkg::CMD_LT:  value = W'(!carry_q);
				u64alu_pkg::CMD_LE:  value = W'(!carry_q || !nz_q);
				default:             value = '0;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/unsigned_64bit_alu.sv]
// ----------------------------------------------------------------------------
// unsigned_64bit_alu: serial unsigned integer ALU
// Add, subtract, multiply, divide, remainder, power and compares on two
// unsigned operands, one result beat per input beat.
// ----------------------------------------------------------------------------
//
// The block takes one command beat at a time and answers with exactly one
// result beat; all arithmetic runs through bit-serial shift registers, so the
// latency depends on the command and on DATA_WIDTH (W). Add, subtract,
// multiply and the compares handle one operand bit per cycle through the
// serial adder or the shift-add multiplier; divide and remainder run one
// restoring shift-subtract step per cycle, and a zero divisor skips the
// steps and returns value 0 with error set. Power runs square-and-multiply
// rounds, each made of two shift-add multiplies in parallel, for as many
// rounds as the exponent has significant bits; an exponent of zero gives
// result 1. Unused command codes answer 0 without error. Another beat is
// taken as soon as the result has moved into the output register, so a
// stalled m_tready costs nothing until the next result is ready. Operands
// are cut to their low W bits and the result is zero-extended.

`default_nettype none

module unsigned_64bit_alu #(
	parameter int DATA_WIDTH = 64
) (
	input  wire          clk,
	input  wire          arst_n,

	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [127:0] s_tdata,   // [63:0] operand_a, [127:64] operand_b
	input  wire  [3:0]   s_tuser,   // [3:0] command

	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [63:0]  m_tdata,   // [63:0] value
	output logic [0:0]   m_tuser    // [0] error
);

	u64alu_pkg::core_ctl_t      ctl;
	u64alu_pkg::core_sts_t      sts;
	logic [DATA_WIDTH-1:0]      core_value;
	logic                       m_tvalid_q;
	logic [63:0]                m_tdata_q;
	logic                       m_tuser_q;

	// take a new beat only while the core sits idle
	assign s_tready     = sts.ready;
	assign ctl.start    = s_tvalid & sts.ready;
	// the output register is free when empty or drained this cycle
	assign ctl.out_free = !m_tvalid_q || m_tready;

	u64alu_core #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (u64alu_pkg::cmd_t'(s_tuser)),
		.opa    (s_tdata[DATA_WIDTH-1:0]),
		.opb    (s_tdata[64+DATA_WIDTH-1:64]),
		.sts    (sts),
		.value  (core_value)
	);

	// output register: hold the beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (sts.done && ctl.out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// payload: load with the valid flag, no reset needed
	always_ff @(posedge clk) begin
		if (sts.done && ctl.out_free) begin
			m_tdata_q <= 64'(core_value);
			m_tuser_q <= sts.error;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

`default_nettype wire
